// ----- src/bdq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded deque package
// Shared field widths, action and status codes, and the controller command.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int ACTION_W = 3;
    localparam int IO_ELEM_W = 16;
    localparam int POSITION_W = 9;
    localparam int COUNT_W = 9;
    localparam int STATUS_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INS_HEAD = 3'd0,
        ACT_INS_TAIL = 3'd1,
        ACT_RM_HEAD  = 3'd2,
        ACT_RM_TAIL  = 3'd3,
        ACT_RD_HEAD  = 3'd4,
        ACT_RD_TAIL  = 3'd5,
        ACT_RD_INDEX = 3'd6,
        ACT_SIZE     = 3'd7
    } bdq_action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } bdq_status_t;

    typedef struct packed {
        logic capture;
    } bdq_cmd_t;

endpackage
`default_nettype wire

// ----- src/bdq_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded deque channels
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface bdq_req_if;
    import bdq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ACTION_W-1:0]   action;
    logic [IO_ELEM_W-1:0]  element;
    logic [POSITION_W-1:0] position;

    modport source (output valid, output action, output element, output position, input ready);
    modport sink (input valid, input action, input element, input position, output ready);
endinterface

interface bdq_rsp_if;
    import bdq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [IO_ELEM_W-1:0] read_value;
    logic [COUNT_W-1:0]   count;
    logic [STATUS_W-1:0]  status;

    modport source (output valid, output read_value, output count, output status, input ready);
    modport sink (input valid, input read_value, input count, input status, output ready);
endinterface
`default_nettype wire

// ----- src/bounded_deque_with_index_read_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded deque with indexed read
// A ring buffer deque that serves insert, remove, read and size requests.
// ----------------------------------------------------------------------------
// The req channel carries one request per transaction: an action code, an
// element for the insert actions and a position for the indexed read.
// The rsp channel returns exactly one transaction per request with the read
// value, the element count after the request and a status code.
// A response is valid in the cycle after its request is accepted, because the
// element store is a memory with a registered read port. The block handles
// one request at a time: it accepts a request, then holds the response until
// it is taken, and takes no new request in between.
// While the receiver holds rsp.ready low, the response stays stable and
// req.ready stays low, so no new request is taken.
// Reset empties the deque and sets the head slot to zero; the store itself
// is not cleared, and no slot is read before it has been written.
// ----------------------------------------------------------------------------
module bounded_deque_with_index_read_core #(
    parameter int CAPACITY   = 256,
    parameter int ELEM_WIDTH = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bdq_req_if.sink   req,
    bdq_rsp_if.source rsp
);
    import bdq_pkg::*;

    bdq_cmd_t cmd;
    logic     in_ready;
    logic     out_valid;

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .out_ready (rsp.ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    bdq_datapath #(
        .CAPACITY   (CAPACITY),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .action     (req.action),
        .element    (req.element),
        .position   (req.position),
        .read_value (rsp.read_value),
        .count      (rsp.count),
        .status     (rsp.status)
    );

    assign req.ready = in_ready;
    assign rsp.valid = out_valid;

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(rsp.valid && req.ready))
        else $error("Request taken while a response is pending.");

    a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> rsp.valid)
        else $error("No response after an accepted request.");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_FULL) |-> (rsp.count == COUNT_W'(CAPACITY)))
        else $error("Full status with a count below capacity.");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_EMPTY) |-> (rsp.count == '0 && rsp.read_value == '0))
        else $error("Empty status with elements held or a value returned.");

endmodule
`default_nettype wire

// ----- src/bdq_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded deque controller
// Accepts one request, then holds the response until it is taken.
// ----------------------------------------------------------------------------
module bdq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              out_ready,
    output logic                   in_ready,
    output logic                   out_valid,
    output bdq_pkg::bdq_cmd_t      cmd
);
    import bdq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RESP
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;
    logic   out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg     <= S_RESP;
                        in_ready_reg  <= 1'b0;
                        out_valid_reg <= 1'b1;
                    end
                end
                S_RESP:
                begin
                    if (out_ready)
                    begin
                        state_reg     <= S_IDLE;
                        in_ready_reg  <= 1'b1;
                        out_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg     <= S_IDLE;
                    in_ready_reg  <= 1'b1;
                    out_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign in_ready    = in_ready_reg;
    assign out_valid   = out_valid_reg;
    assign cmd.capture = in_valid && in_ready_reg;

endmodule
`default_nettype wire

// ----- src/bdq_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded deque datapath
// Ring buffer store, head pointer, fill count and the response registers.
// ----------------------------------------------------------------------------
module bdq_datapath #(
    parameter int CAPACITY   = 256,
    parameter int ELEM_WIDTH = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire bdq_pkg::bdq_cmd_t              cmd,
    input  wire logic [bdq_pkg::ACTION_W-1:0]   action,
    input  wire logic [bdq_pkg::IO_ELEM_W-1:0]  element,
    input  wire logic [bdq_pkg::POSITION_W-1:0] position,
    output logic [bdq_pkg::IO_ELEM_W-1:0]       read_value,
    output logic [bdq_pkg::COUNT_W-1:0]         count,
    output logic [bdq_pkg::STATUS_W-1:0]        status
);
    import bdq_pkg::*;

    localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [PTR_W:0]   CAP_WRAP = (PTR_W + 1)'(CAPACITY);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(CAPACITY - 1);
    localparam logic [CMP_W-1:0] CAP_CMP = CMP_W'(CAPACITY);

    logic [ELEM_WIDTH-1:0] mem [CAPACITY];

    logic [CNT_W-1:0]      fill_reg;
    logic [CNT_W-1:0]      fill_next;
    logic [PTR_W-1:0]      head_reg;
    logic [PTR_W-1:0]      head_next;
    logic [ELEM_WIDTH-1:0] rd_data_reg;
    logic                  hit_reg;
    logic                  hit_next;
    bdq_status_t           status_reg;
    bdq_status_t           status_next;

    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;
    logic                  rd_en;
    logic [PTR_W-1:0]      rd_addr;
    logic                  full;
    logic                  empty;
    logic [PTR_W-1:0]      head_dec;
    logic [PTR_W-1:0]      head_inc;
    logic [PTR_W-1:0]      tail_slot;
    logic [PTR_W-1:0]      last_slot;
    logic [PTR_W-1:0]      index_slot;
    logic [CMP_W-1:0]      pos_cmp;
    logic [CMP_W-1:0]      fill_cmp;
    logic [ELEM_WIDTH-1:0] elem_in;

    function automatic logic [PTR_W-1:0] slot_at(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W-1:0] off);
        logic [PTR_W:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= CAP_WRAP)
        begin
            s = s - CAP_WRAP;
        end
        return s[PTR_W-1:0];
    endfunction

    always_comb
    begin
        full       = (fill_reg == CAP_CNT);
        empty      = (fill_reg == '0);
        head_dec   = (head_reg == '0) ? LAST_SLOT : head_reg - 1'b1;
        head_inc   = slot_at(head_reg, PTR_W'(1));
        tail_slot  = slot_at(head_reg, PTR_W'(fill_reg));
        last_slot  = slot_at(head_reg, PTR_W'(fill_reg - 1'b1));
        index_slot = slot_at(head_reg, PTR_W'(position));
        pos_cmp    = CMP_W'(position);
        fill_cmp   = CMP_W'(fill_reg);
        elem_in    = ELEM_WIDTH'(element);

        wr_en       = 1'b0;
        wr_addr     = tail_slot;
        rd_en       = 1'b0;
        rd_addr     = head_reg;
        hit_next    = 1'b0;
        status_next = ST_OK;
        fill_next   = fill_reg;
        head_next   = head_reg;

        case (bdq_action_t'(action))
            ACT_INS_HEAD:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en     = 1'b1;
                    wr_addr   = head_dec;
                    head_next = head_dec;
                    fill_next = fill_reg + 1'b1;
                end
            end
            ACT_INS_TAIL:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en     = 1'b1;
                    wr_addr   = tail_slot;
                    fill_next = fill_reg + 1'b1;
                end
            end
            ACT_RM_HEAD:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    head_next = head_inc;
                    fill_next = fill_reg - 1'b1;
                end
            end
            ACT_RM_TAIL:
            begin
                if (!empty)
                begin
                    fill_next = fill_reg - 1'b1;
                end
            end
            ACT_RD_HEAD:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = head_reg;
                    hit_next = 1'b1;
                end
            end
            ACT_RD_TAIL:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = last_slot;
                    hit_next = 1'b1;
                end
            end
            ACT_RD_INDEX:
            begin
                if (pos_cmp >= CAP_CMP)
                begin
                    status_next = ST_RANGE;
                end
                else if (pos_cmp < fill_cmp)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = index_slot;
                    hit_next = 1'b1;
                end
            end
            ACT_SIZE:
            begin
                status_next = ST_OK;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            head_reg   <= '0;
            hit_reg    <= 1'b0;
            status_reg <= ST_OK;
        end
        else if (cmd.capture)
        begin
            fill_reg   <= fill_next;
            head_reg   <= head_next;
            hit_reg    <= hit_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture && wr_en)
        begin
            mem[wr_addr] <= elem_in;
        end
        if (cmd.capture && rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign read_value = hit_reg ? IO_ELEM_W'(rd_data_reg) : '0;
    assign count      = COUNT_W'(fill_reg);
    assign status     = status_reg;

endmodule
`default_nettype wire

// ----- bench/bounded_deque_with_index_read_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounded deque with indexed read: block test
// Drives requests on the req channel, predicts each response from a private
// model of the ring buffer, and compares every response field by field.
// Directed requests cover the empty, boundary and out-of-range cases, then
// random traffic fills the deque to capacity and drains it again under
// changing backpressure, including one long response stall.
// ----------------------------------------------------------------------------
module bounded_deque_with_index_read_core_test;
    import bdq_pkg::*;

    localparam int CAPACITY = 256;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AT = 250;
    localparam int SETTLE_CYCLES = 8;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} traffic_mix_t;

    typedef struct packed {
        logic [IO_ELEM_W-1:0] read_value;
        logic [COUNT_W-1:0]   count;
        bdq_status_t          status;
    } deque_answer_t;

    class deque_scoreboard;
        logic [IO_ELEM_W-1:0] slots [CAPACITY];
        int fill;
        int head;
        int mismatches;
        deque_answer_t pending [$];

        function new();
            fill = 0;
            head = 0;
            mismatches = 0;
        endfunction

        function int slot_after(int off);
            return (head + off) % CAPACITY;
        endfunction

        function bit drained();
            return pending.size() == 0;
        endfunction

        function void note_request(bdq_action_t act, logic [IO_ELEM_W-1:0] elem,
                                   logic [POSITION_W-1:0] pos);
            deque_answer_t ans;
            ans.read_value = '0;
            ans.status = ST_OK;
            case (act)
                ACT_INS_HEAD:
                    if (fill >= CAPACITY)
                        ans.status = ST_FULL;
                    else
                    begin
                        head = (head + CAPACITY - 1) % CAPACITY;
                        slots[head] = elem;
                        fill++;
                    end
                ACT_INS_TAIL:
                    if (fill >= CAPACITY)
                        ans.status = ST_FULL;
                    else
                    begin
                        slots[slot_after(fill)] = elem;
                        fill++;
                    end
                ACT_RM_HEAD:
                    if (fill == 0)
                        ans.status = ST_EMPTY;
                    else
                    begin
                        head = slot_after(1);
                        fill--;
                    end
                ACT_RM_TAIL:
                    if (fill != 0)
                        fill--;
                ACT_RD_HEAD:
                    if (fill == 0)
                        ans.status = ST_EMPTY;
                    else
                        ans.read_value = slots[head];
                ACT_RD_TAIL:
                    if (fill == 0)
                        ans.status = ST_EMPTY;
                    else
                        ans.read_value = slots[slot_after(fill - 1)];
                ACT_RD_INDEX:
                    if (int'(pos) >= CAPACITY)
                        ans.status = ST_RANGE;
                    else if (int'(pos) < fill)
                        ans.read_value = slots[slot_after(int'(pos))];
                default:
                    ;
            endcase
            ans.count = COUNT_W'(fill);
            pending.push_back(ans);
        endfunction

        function void check_response(logic [IO_ELEM_W-1:0] rv, logic [COUNT_W-1:0] cnt,
                                     logic [STATUS_W-1:0] st);
            deque_answer_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected response: read_value %h count %0d status %0d",
                         $time, rv, cnt, st);
                return;
            end
            want = pending.pop_front();
            if (rv !== want.read_value)
            begin
                mismatches++;
                $display("%0t: read_value expected %h actual %h", $time, want.read_value, rv);
            end
            if (cnt !== want.count)
            begin
                mismatches++;
                $display("%0t: count expected %0d actual %0d", $time, want.count, cnt);
            end
            if (st !== want.status)
            begin
                mismatches++;
                $display("%0t: status expected %0d actual %0d", $time, want.status, st);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    bdq_req_if req ();
    bdq_rsp_if rsp ();

    bounded_deque_with_index_read_core #(
        .CAPACITY   (CAPACITY),
        .ELEM_WIDTH (IO_ELEM_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    deque_scoreboard sb = new();

    int send_idle_pct = 24;
    int recv_idle_pct = 65;
    int requests_offered = 0;
    int requests_taken = 0;
    int quiet_cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic offer_request(bdq_action_t act, logic [IO_ELEM_W-1:0] elem,
                                 logic [POSITION_W-1:0] pos);
        if (requests_offered < 700)
        begin
            send_idle_pct = 24;
            recv_idle_pct = 65;
        end
        else if (requests_offered < 1400)
        begin
            send_idle_pct = 65;
            recv_idle_pct = 24;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        requests_offered++;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid = 1'b0;
            @(negedge clk);
        end
        req.valid = 1'b1;
        req.action = act;
        req.element = elem;
        req.position = pos;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sb.note_request(act, elem, pos);
        requests_taken++;
        @(negedge clk);
    endtask

    function automatic bdq_action_t pick_read();
        case ($urandom_range(3))
            0: return ACT_RD_HEAD;
            1: return ACT_RD_TAIL;
            2: return ACT_RD_INDEX;
            default: return ACT_SIZE;
        endcase
    endfunction

    function automatic bdq_action_t pick_action(traffic_mix_t mix);
        int roll;
        bit grow_side;
        roll = $urandom_range(99);
        if (mix == MIX_EVEN)
            return bdq_action_t'($urandom_range(7));
        grow_side = (mix == MIX_GROW) ? (roll < 75) : (roll >= 75 && roll < 85);
        if (grow_side)
            return $urandom_range(1) ? ACT_INS_HEAD : ACT_INS_TAIL;
        if ((mix == MIX_GROW && roll < 85) || (mix == MIX_SHRINK && roll < 75))
            return $urandom_range(1) ? ACT_RM_HEAD : ACT_RM_TAIL;
        return pick_read();
    endfunction

    function automatic logic [POSITION_W-1:0] pick_position();
        case ($urandom_range(3))
            0, 1: return (sb.fill > 0) ? POSITION_W'($urandom_range(sb.fill - 1)) : '0;
            2: return (sb.fill < CAPACITY) ?
                   POSITION_W'($urandom_range(CAPACITY - 1, sb.fill)) :
                   POSITION_W'($urandom_range(511, CAPACITY));
            default: return POSITION_W'($urandom_range(511));
        endcase
    endfunction

    task automatic run_random(traffic_mix_t mix, int n);
        bdq_action_t act;
        for (int i = 0; i < n; i++)
        begin
            act = pick_action(mix);
            offer_request(act, IO_ELEM_W'($urandom), pick_position());
        end
    endtask

    initial
    begin
        rsp.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            int hold_left;
            bit pressure_done;
            @(negedge clk);
            if (!pressure_done && requests_taken >= HOLD_OFF_AT)
            begin
                pressure_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready = 1'b0;
            end
            else
                rsp.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_response(rsp.read_value, rsp.count, rsp.status);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        req.valid = 1'b0;
        req.action = ACT_SIZE;
        req.element = '0;
        req.position = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        offer_request(ACT_SIZE, 16'h5a5a, 9'd0);
        offer_request(ACT_RM_HEAD, 16'h0000, 9'd0);
        offer_request(ACT_RM_TAIL, 16'hffff, 9'd511);
        offer_request(ACT_RD_HEAD, 16'h0000, 9'd0);
        offer_request(ACT_RD_TAIL, 16'h0000, 9'd0);
        offer_request(ACT_RD_INDEX, 16'h0000, 9'd0);
        offer_request(ACT_RD_INDEX, 16'h0000, 9'd511);
        offer_request(ACT_INS_HEAD, 16'hffff, 9'd0);
        offer_request(ACT_INS_TAIL, 16'h0000, 9'd0);
        offer_request(ACT_INS_HEAD, 16'h1234, 9'd0);
        offer_request(ACT_RD_HEAD, 16'h0000, 9'd0);
        offer_request(ACT_RD_TAIL, 16'h0000, 9'd0);
        offer_request(ACT_RD_INDEX, 16'h0000, 9'd0);
        offer_request(ACT_RD_INDEX, 16'h0000, 9'd1);
        offer_request(ACT_RD_INDEX, 16'h0000, 9'd2);
        offer_request(ACT_RD_INDEX, 16'h0000, 9'd3);
        offer_request(ACT_RD_INDEX, 16'h0000, 9'd255);
        offer_request(ACT_RD_INDEX, 16'h0000, 9'd256);
        offer_request(ACT_RM_TAIL, 16'h0000, 9'd0);
        offer_request(ACT_RM_HEAD, 16'h0000, 9'd0);
        offer_request(ACT_SIZE, 16'h0000, 9'd0);
        offer_request(ACT_RD_TAIL, 16'h0000, 9'd0);

        run_random(MIX_GROW, 500);
        run_random(MIX_SHRINK, 400);
        run_random(MIX_EVEN, 300);
        run_random(MIX_GROW, 500);
        run_random(MIX_SHRINK, 300);
        req.valid = 1'b0;

        while (!sb.drained())
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
